@@ rtl/irc_line_tokenizer_assert.svh @@
// Assertion macros shared by the IRC line tokenizer RTL.
`ifndef IRC_LINE_TOKENIZER_ASSERT_SVH
`define IRC_LINE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define IRCLT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define IRCLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/irclt_pkg.sv @@
// Shared types and constants of the IRC line tokenizer.
package irclt_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam int KIND_W      = 3;
	localparam int INDEX_W     = 4;
	localparam int OUT_POS_W   = 10;
	localparam int PARAM_REACH = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_PREFIX   = 3'd0,
		KIND_CMD      = 3'd1,
		KIND_MID      = 3'd2,
		KIND_TRAIL    = 3'd3,
		KIND_OVERLONG = 3'd4,
		KIND_NOCMD    = 3'd5
	} kind_t;

	// Summary of a finished line, parser to emitter.
	typedef struct packed {
		logic overflow;
		logic has_cmd;
	} line_sum_t;

endpackage

@@ rtl/irclt_channels.sv @@
// Valid/ready channel interfaces: received bytes in, token descriptors out.
interface irclt_byte_if;
	import irclt_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface irclt_tok_if;
	import irclt_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [INDEX_W-1:0]   param_index;
	logic [OUT_POS_W-1:0] token_start;
	logic [OUT_POS_W-1:0] token_length;
	logic                 last;

	modport source (output valid, output kind, output param_index, output token_start,
		output token_length, output last, input ready);
	modport sink (input valid, input kind, input param_index, input token_start,
		input token_length, input last, output ready);
endinterface

@@ rtl/irclt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module irclt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/irclt_parse.sv @@
// Byte parser: tracks line state and writes token entries into the table RAM.
module irclt_parse #(
	parameter int BUFFER_BYTES = 1024,
	parameter int MAX_PARAMS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	irclt_byte_if.sink                             rx,
	output logic                                   wr_en,
	output logic [$clog2((MAX_PARAMS < irclt_pkg::PARAM_REACH ? MAX_PARAMS :
		irclt_pkg::PARAM_REACH) + 2)-1:0]            wr_addr,
	output logic [irclt_pkg::KIND_W + irclt_pkg::INDEX_W +
		2*$clog2(BUFFER_BYTES):0]                    wr_data,
	output irclt_pkg::line_sum_t                   sum,
	output logic [$clog2((MAX_PARAMS < irclt_pkg::PARAM_REACH ? MAX_PARAMS :
		irclt_pkg::PARAM_REACH) + 3)-1:0]            count,
	output logic [$clog2(BUFFER_BYTES)-1:0]        content_end,
	output logic                                   line_done,
	input  logic                                   clear
);
	import irclt_pkg::*;

	localparam int POS_W     = $clog2(BUFFER_BYTES);
	localparam int PARAM_CAP = MAX_PARAMS < PARAM_REACH ? MAX_PARAMS : PARAM_REACH;
	localparam int DEPTH     = PARAM_CAP + 2;
	localparam int SLOT_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int PCNT_W    = $clog2(PARAM_CAP + 1);

	typedef enum logic [6:0] {
		PH_LEAD   = 7'b0000001,
		PH_PREFIX = 7'b0000010,
		PH_GAP    = 7'b0000100,
		PH_CMD    = 7'b0001000,
		PH_PGAP   = 7'b0010000,
		PH_MID    = 7'b0100000,
		PH_TRAIL  = 7'b1000000
	} phase_t;

	logic               busy_q;
	logic [POS_W-1:0]   lpos_q;
	logic               ovf_q;
	logic [POS_W-1:0]   cend_q, cend_d;
	logic               zero_q, zero_d;
	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   count_q;
	logic [PCNT_W-1:0]  pcnt_q, pcnt_d;
	logic               cmd_q;
	logic [POS_W-1:0]   cmd_start_q;
	logic               open_v_q, open_v_d;
	kind_t              open_kind_q;
	logic [INDEX_W-1:0] open_idx_q;
	logic [POS_W-1:0]   open_start_q;
	logic [SLOT_W-1:0]  open_slot_q;

	logic               acc, is_lf, stored, fits;
	logic [7:0]         b;
	logic [POS_W-1:0]   pos1;
	logic               do_add, do_close, want_param;
	kind_t              add_kind;
	logic [INDEX_W-1:0] add_idx;
	logic [POS_W-1:0]   add_start;

	assign rx.ready    = !busy_q;
	assign b           = rx.data_byte;
	assign acc         = rx.valid && !busy_q;
	assign is_lf       = b == CH_LF;
	assign stored      = acc && !is_lf && (lpos_q < POS_W'(BUFFER_BYTES - 1));
	assign pos1        = lpos_q + POS_W'(1);
	assign fits        = count_q < CNT_W'(DEPTH);
	assign line_done   = acc && is_lf;
	assign count       = count_q;
	assign content_end = cend_q;
	assign sum.overflow = ovf_q;
	assign sum.has_cmd  = cmd_q && (cmd_start_q < cend_q);

	always_comb begin
		phase_d    = phase_q;
		zero_d     = zero_q;
		cend_d     = cend_q;
		pcnt_d     = pcnt_q;
		do_add     = 1'b0;
		do_close   = 1'b0;
		want_param = 1'b0;
		add_kind   = KIND_CMD;
		add_idx    = '0;
		add_start  = lpos_q;
		if (stored && !zero_q) begin
			if (b == CH_NUL) begin
				zero_d = 1'b1;
				cend_d = lpos_q;
			end else begin
				if (b != CH_CR) begin
					cend_d = pos1;
				end
				case (phase_q)
					PH_LEAD: begin
						if (b == CH_COLON) begin
							do_add    = 1'b1;
							add_kind  = KIND_PREFIX;
							add_start = pos1;
							phase_d   = PH_PREFIX;
						end else if (b != CH_SPACE) begin
							do_add  = 1'b1;
							phase_d = PH_CMD;
						end
					end
					PH_PREFIX: begin
						if (b == CH_SPACE) begin
							do_close = 1'b1;
							phase_d  = PH_GAP;
						end
					end
					PH_GAP: begin
						if (b != CH_SPACE) begin
							do_add  = 1'b1;
							phase_d = PH_CMD;
						end
					end
					PH_CMD, PH_MID: begin
						if (b == CH_SPACE) begin
							do_close = 1'b1;
							phase_d  = PH_PGAP;
						end
					end
					PH_PGAP: begin
						if (b == CH_COLON) begin
							want_param = 1'b1;
							add_kind   = KIND_TRAIL;
							add_start  = pos1;
							phase_d    = PH_TRAIL;
						end else if (b != CH_SPACE) begin
							want_param = 1'b1;
							add_kind   = KIND_MID;
							phase_d    = PH_MID;
						end
					end
					default: begin
					end
				endcase
			end
		end
		// parameters past the cap are parsed but leave no entry
		if (want_param && (pcnt_q < PCNT_W'(PARAM_CAP))) begin
			do_add  = 1'b1;
			add_idx = INDEX_W'(pcnt_q);
			pcnt_d  = pcnt_q + PCNT_W'(1);
		end
	end

	always_comb begin
		if (do_add) begin
			open_v_d = fits;
		end else if (do_close || want_param) begin
			open_v_d = 1'b0;
		end else begin
			open_v_d = open_v_q;
		end
		wr_en   = (do_add && fits) || (do_close && open_v_q);
		wr_addr = do_add ? count_q[SLOT_W-1:0] : open_slot_q;
		wr_data = do_add ? {add_kind, add_idx, add_start, add_start, 1'b0}
			: {open_kind_q, open_idx_q, open_start_q, lpos_q, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			lpos_q   <= '0;
			ovf_q    <= 1'b0;
			cend_q   <= '0;
			zero_q   <= 1'b0;
			phase_q  <= PH_LEAD;
			count_q  <= '0;
			pcnt_q   <= '0;
			cmd_q    <= 1'b0;
			open_v_q <= 1'b0;
		end else if (clear) begin
			busy_q   <= 1'b0;
			lpos_q   <= '0;
			ovf_q    <= 1'b0;
			cend_q   <= '0;
			zero_q   <= 1'b0;
			phase_q  <= PH_LEAD;
			count_q  <= '0;
			pcnt_q   <= '0;
			cmd_q    <= 1'b0;
			open_v_q <= 1'b0;
		end else begin
			if (line_done) begin
				busy_q <= 1'b1;
			end
			if (stored) begin
				lpos_q <= pos1;
			end else if (acc && !is_lf) begin
				ovf_q <= 1'b1;
			end
			cend_q   <= cend_d;
			zero_q   <= zero_d;
			phase_q  <= phase_d;
			pcnt_q   <= pcnt_d;
			open_v_q <= open_v_d;
			if (do_add && fits) begin
				count_q <= count_q + CNT_W'(1);
				if (add_kind == KIND_CMD) begin
					cmd_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_add && fits) begin
			open_kind_q  <= add_kind;
			open_idx_q   <= add_idx;
			open_start_q <= add_start;
			open_slot_q  <= count_q[SLOT_W-1:0];
			if (add_kind == KIND_CMD) begin
				cmd_start_q <= add_start;
			end
		end
	end
endmodule

@@ rtl/irclt_emit.sv @@
// Line-end emitter: walks the token table and drives the descriptor output register.
module irclt_emit #(
	parameter int BUFFER_BYTES = 1024,
	parameter int MAX_PARAMS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	irclt_tok_if.source                            tx,
	input  logic                                   line_done,
	input  irclt_pkg::line_sum_t                   sum,
	input  logic [$clog2((MAX_PARAMS < irclt_pkg::PARAM_REACH ? MAX_PARAMS :
		irclt_pkg::PARAM_REACH) + 3)-1:0]            count,
	input  logic [$clog2(BUFFER_BYTES)-1:0]        content_end,
	output logic                                   rd_en,
	output logic [$clog2((MAX_PARAMS < irclt_pkg::PARAM_REACH ? MAX_PARAMS :
		irclt_pkg::PARAM_REACH) + 2)-1:0]            rd_addr,
	input  logic [irclt_pkg::KIND_W + irclt_pkg::INDEX_W +
		2*$clog2(BUFFER_BYTES):0]                    rd_data,
	output logic                                   clear
);
	import irclt_pkg::*;

	localparam int POS_W     = $clog2(BUFFER_BYTES);
	localparam int PARAM_CAP = MAX_PARAMS < PARAM_REACH ? MAX_PARAMS : PARAM_REACH;
	localparam int DEPTH     = PARAM_CAP + 2;
	localparam int SLOT_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int ENTRY_W   = KIND_W + INDEX_W + 2*POS_W + 1;
	localparam int IDX_HI    = ENTRY_W - KIND_W - 1;
	localparam int START_HI  = IDX_HI - INDEX_W;
	localparam int END_HI    = START_HI - POS_W;
	localparam int WIDE_W    = POS_W > OUT_POS_W ? POS_W : OUT_POS_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_STATUS = 5'b00010,
		ST_READ   = 5'b00100,
		ST_EVAL   = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     idx_q, idx_d;
	logic                 out_v_q, pend_v_q;
	kind_t                st_kind_q;
	kind_t                out_kind_q, pend_kind_q;
	logic [INDEX_W-1:0]   out_idx_q, pend_idx_q;
	logic [OUT_POS_W-1:0] out_start_q, pend_start_q;
	logic [OUT_POS_W-1:0] out_len_q, pend_len_q;
	logic                 out_last_q;

	kind_t                e_kind;
	logic [INDEX_W-1:0]   e_idx;
	logic [POS_W-1:0]     e_start, e_end, end_sel, len_full;
	logic                 e_closed, skip, out_free, adv_last;
	logic [WIDE_W-1:0]    start_wide, len_wide;
	logic                 out_load, out_status, out_last, pend_load, pend_clr;

	assign e_kind   = kind_t'(rd_data[ENTRY_W-1 -: KIND_W]);
	assign e_idx    = rd_data[IDX_HI -: INDEX_W];
	assign e_start  = rd_data[START_HI -: POS_W];
	assign e_end    = rd_data[END_HI -: POS_W];
	assign e_closed = rd_data[0];

	// commands and middles made only of stripped CRs drop out
	assign skip     = ((e_kind == KIND_CMD) || (e_kind == KIND_MID)) && (e_start >= content_end);
	assign end_sel  = (e_closed && (e_end < content_end)) ? e_end : content_end;
	assign len_full = (end_sel > e_start) ? (end_sel - e_start) : '0;
	assign start_wide = WIDE_W'(e_start);
	assign len_wide   = WIDE_W'(len_full);

	assign out_free = !out_v_q || tx.ready;
	assign adv_last = (idx_q + CNT_W'(1)) >= count;
	assign rd_addr  = idx_q[SLOT_W-1:0];

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		rd_en      = 1'b0;
		clear      = 1'b0;
		out_load   = 1'b0;
		out_status = 1'b0;
		out_last   = 1'b0;
		pend_load  = 1'b0;
		pend_clr   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (line_done) begin
					if (sum.overflow || !sum.has_cmd) begin
						state_d = ST_STATUS;
					end else begin
						idx_d   = '0;
						state_d = ST_READ;
					end
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = 1'b1;
					out_last   = 1'b1;
					clear      = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				// hold one item back so the final one can carry last
				if (skip || !pend_v_q || out_free) begin
					if (!skip) begin
						pend_load = 1'b1;
						out_load  = pend_v_q;
					end
					if (adv_last) begin
						state_d = ST_FLUSH;
					end else begin
						idx_d   = idx_q + CNT_W'(1);
						state_d = ST_READ;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = 1'b1;
					pend_clr = 1'b1;
					clear    = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (tx.ready) begin
				out_v_q <= 1'b0;
			end
			if (pend_load) begin
				pend_v_q <= 1'b1;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && line_done) begin
			st_kind_q <= sum.overflow ? KIND_OVERLONG : KIND_NOCMD;
		end
		if (out_load) begin
			out_last_q <= out_last;
			if (out_status) begin
				out_kind_q  <= st_kind_q;
				out_idx_q   <= '0;
				out_start_q <= '0;
				out_len_q   <= '0;
			end else begin
				out_kind_q  <= pend_kind_q;
				out_idx_q   <= pend_idx_q;
				out_start_q <= pend_start_q;
				out_len_q   <= pend_len_q;
			end
		end
		if (pend_load) begin
			pend_kind_q  <= e_kind;
			pend_idx_q   <= e_idx;
			pend_start_q <= start_wide[OUT_POS_W-1:0];
			pend_len_q   <= len_wide[OUT_POS_W-1:0];
		end
	end

	assign tx.valid        = out_v_q;
	assign tx.kind         = out_kind_q;
	assign tx.param_index  = out_idx_q;
	assign tx.token_start  = out_start_q;
	assign tx.token_length = out_len_q;
	assign tx.last         = out_last_q;
endmodule

@@ rtl/irc_line_tokenizer.sv @@
// Top level of the IRC line tokenizer: byte parser, token table RAM and emitter.
//
//  channel     dir  payload                                          handshake
//  line_bytes  in   data_byte[7:0]                                   valid/ready
//  tokens      out  kind[2:0] param_index[3:0] token_start[9:0]      valid/ready
//                   token_length[9:0] last
//
// Within a line one byte request is taken per cycle; each byte opens or closes at most
// one token entry in the table RAM, so the RAM sees at most one write a cycle.
// A newline holds off line_bytes until the line's last descriptor is loaded into the
// output register: via the status state for a status item, else through a RAM read
// and then an evaluate state per table entry, and a final flush state.
// A stalled tokens sink freezes the table walk; the next line's bytes are taken
// while the final descriptor still waits in the output register.
// arst_n clears line state and handshake control; the table RAM needs no clearing,
// as only entries written during the current line are read.
`include "irc_line_tokenizer_assert.svh"

module irc_line_tokenizer #(
	parameter int BUFFER_BYTES = 1024,
	parameter int MAX_PARAMS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	irclt_byte_if.sink  line_bytes,
	irclt_tok_if.source tokens
);
	import irclt_pkg::*;

	localparam int POS_W     = $clog2(BUFFER_BYTES);
	localparam int PARAM_CAP = MAX_PARAMS < PARAM_REACH ? MAX_PARAMS : PARAM_REACH;
	// prefix, command and the emitted parameters
	localparam int TABLE_DEPTH = PARAM_CAP + 2;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	// entry: kind, param index, start, end, closed
	localparam int ENTRY_W     = KIND_W + INDEX_W + 2*POS_W + 1;

	logic               wr_en, rd_en;
	logic [SLOT_W-1:0]  wr_addr, rd_addr;
	logic [ENTRY_W-1:0] wr_data, rd_data;
	line_sum_t          sum;
	logic [CNT_W-1:0]   count;
	logic [POS_W-1:0]   content_end;
	logic               line_done, clear;

	// per-byte parse; owns the line-level state and the write port
	irclt_parse #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MAX_PARAMS   (MAX_PARAMS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (line_bytes),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.sum         (sum),
		.count       (count),
		.content_end (content_end),
		.line_done   (line_done),
		.clear       (clear)
	);

	// token table
	irclt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// line-end walk over the table; clips lengths against the content end
	irclt_emit #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MAX_PARAMS   (MAX_PARAMS)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.tx          (tokens),
		.line_done   (line_done),
		.sum         (sum),
		.count       (count),
		.content_end (content_end),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.clear       (clear)
	);

	`IRCLT_ASSERT_NEXT(a_lf_holds_input, line_bytes.valid && line_bytes.ready && line_bytes.data_byte == CH_LF, !line_bytes.ready, "byte request taken right after a newline")
	`IRCLT_ASSERT_NOW(a_walk_excludes_parse, rd_en, !line_bytes.ready && !wr_en, "table read overlaps the parse")
	`IRCLT_ASSERT_NOW(a_status_is_last, tokens.valid && (tokens.kind == KIND_OVERLONG || tokens.kind == KIND_NOCMD), tokens.last && tokens.token_length == '0 && tokens.token_start == '0, "status item not a bare final item")
	`IRCLT_ASSERT_NOW(a_count_in_range, 1'b1, count <= CNT_W'(TABLE_DEPTH), "token count past the table depth")
endmodule

@@ tb/tb_irc_line_tokenizer.sv @@
// Self-checking testbench of the IRC line tokenizer: byte stream in, token descriptors out.
import irclt_pkg::*;

// One token descriptor as it leaves the block.
typedef struct packed {
	kind_t                kind;
	logic [INDEX_W-1:0]   idx;
	logic [OUT_POS_W-1:0] start;
	logic [OUT_POS_W-1:0] len;
	logic                 last;
} token_desc_t;

class token_scoreboard #(int BUF_BYTES = 1024, int PARAMS_MAX = 16);
	localparam int TAB_DEPTH   = 18;
	localparam int PARAM_LIMIT = (PARAMS_MAX < PARAM_REACH) ? PARAMS_MAX : PARAM_REACH;
	localparam int MAX_REPORTS = 10;

	typedef enum int {
		PH_LEAD, PH_PREFIX, PH_AFTER_PREFIX, PH_CMD, PH_PARAM_GAP, PH_MID, PH_TRAIL
	} parse_phase_e;

	typedef struct {
		kind_t kind;
		int    idx;
		int    start;
		int    stop;
		bit    closed;
	} tok_entry_t;

	// line state
	int           line_pos;
	bit           overflow;
	int           content_end;
	bit           zero_seen;
	parse_phase_e phase;
	int           tok_cnt;
	tok_entry_t   tok_tab[TAB_DEPTH];
	int           param_cnt;
	int           open_slot;

	token_desc_t  pending_tokens[$];
	int           failures;
	int           checked;
	int           lines;
	int           status_items;
	int           predicted;

	function new();
		clear_line();
	endfunction

	function void clear_line();
		line_pos    = 0;
		overflow    = 0;
		content_end = 0;
		zero_seen   = 0;
		phase       = PH_LEAD;
		tok_cnt     = 0;
		param_cnt   = 0;
		open_slot   = -1;
	endfunction

	function void open_token(kind_t k, int idx, int start);
		if (tok_cnt >= TAB_DEPTH) begin
			open_slot = -1;
			return;
		end
		tok_tab[tok_cnt] = '{kind: k, idx: idx, start: start, stop: start, closed: 1'b0};
		open_slot = tok_cnt;
		tok_cnt++;
	endfunction

	function void close_open(int pos);
		if (open_slot >= 0) begin
			tok_tab[open_slot].stop   = pos;
			tok_tab[open_slot].closed = 1'b1;
		end
		open_slot = -1;
	endfunction

	// params past the limit are tracked by phase only
	function void open_param(kind_t k, int start);
		if (param_cnt < PARAM_LIMIT) begin
			open_token(k, param_cnt, start);
			param_cnt++;
		end else begin
			open_slot = -1;
		end
	endfunction

	function void parse_byte(logic [7:0] b, int pos);
		if (zero_seen)
			return;
		if (b == CH_NUL) begin
			zero_seen   = 1;
			content_end = pos;
			return;
		end
		if (b != CH_CR)
			content_end = pos + 1;
		case (phase)
			PH_LEAD: begin
				if (b == CH_COLON) begin
					open_token(KIND_PREFIX, 0, pos + 1);
					phase = PH_PREFIX;
				end else if (b != CH_SPACE) begin
					open_token(KIND_CMD, 0, pos);
					phase = PH_CMD;
				end
			end
			PH_PREFIX: begin
				if (b == CH_SPACE) begin
					close_open(pos);
					phase = PH_AFTER_PREFIX;
				end
			end
			PH_AFTER_PREFIX: begin
				if (b != CH_SPACE) begin
					open_token(KIND_CMD, 0, pos);
					phase = PH_CMD;
				end
			end
			PH_CMD: begin
				if (b == CH_SPACE) begin
					close_open(pos);
					phase = PH_PARAM_GAP;
				end
			end
			PH_PARAM_GAP: begin
				if (b == CH_COLON) begin
					open_param(KIND_TRAIL, pos + 1);
					phase = PH_TRAIL;
				end else if (b != CH_SPACE) begin
					open_param(KIND_MID, pos);
					phase = PH_MID;
				end
			end
			PH_MID: begin
				if (b == CH_SPACE) begin
					close_open(pos);
					phase = PH_PARAM_GAP;
				end
			end
			default: ;
		endcase
	endfunction

	function void push_status(kind_t k);
		token_desc_t d;
		d      = '0;
		d.kind = k;
		d.last = 1'b1;
		pending_tokens.push_back(d);
		status_items++;
		predicted++;
	endfunction

	// newline: turn the token table into descriptors
	function void close_line();
		bit          has_cmd;
		int          stop;
		token_desc_t d;
		token_desc_t line_q[$];
		has_cmd = 0;
		if (overflow) begin
			push_status(KIND_OVERLONG);
			return;
		end
		for (int i = 0; i < tok_cnt; i++)
			if (tok_tab[i].kind == KIND_CMD && tok_tab[i].start < content_end)
				has_cmd = 1;
		if (!has_cmd) begin
			push_status(KIND_NOCMD);
			return;
		end
		for (int i = 0; i < tok_cnt; i++) begin
			// command or middle made only of stripped CRs is no token
			if ((tok_tab[i].kind == KIND_CMD || tok_tab[i].kind == KIND_MID) &&
					tok_tab[i].start >= content_end)
				continue;
			stop = content_end;
			if (tok_tab[i].closed && tok_tab[i].stop < stop)
				stop = tok_tab[i].stop;
			d.kind  = tok_tab[i].kind;
			d.idx   = tok_tab[i].idx[INDEX_W-1:0];
			d.start = tok_tab[i].start[OUT_POS_W-1:0];
			d.len   = (stop > tok_tab[i].start) ?
				OUT_POS_W'(stop - tok_tab[i].start) : '0;
			d.last  = 1'b0;
			line_q.push_back(d);
		end
		line_q[line_q.size() - 1].last = 1'b1;
		predicted += line_q.size();
		pending_tokens = {pending_tokens, line_q};
	endfunction

	// one accepted byte request
	function void take_byte(logic [7:0] b);
		if (b == CH_LF) begin
			close_line();
			clear_line();
			lines++;
		end else if (line_pos < BUF_BYTES - 1) begin
			line_pos++;
			parse_byte(b, line_pos - 1);
		end else begin
			overflow = 1;
		end
	endfunction

	function void report(string what, token_desc_t got, token_desc_t want);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("ERROR %s: got kind=%0d idx=%0d start=%0d len=%0d last=%0b, want kind=%0d idx=%0d start=%0d len=%0d last=%0b",
				what, got.kind, got.idx, got.start, got.len, got.last,
				want.kind, want.idx, want.start, want.len, want.last);
	endfunction

	function void check_descriptor(token_desc_t got);
		token_desc_t want;
		string       diff;
		diff = "";
		if (pending_tokens.size() == 0) begin
			report("descriptor with none pending", got, '0);
			return;
		end
		want = pending_tokens.pop_front();
		checked++;
		if (got.kind !== want.kind)   diff = {diff, " kind"};
		if (got.idx !== want.idx)     diff = {diff, " param_index"};
		if (got.start !== want.start) diff = {diff, " token_start"};
		if (got.len !== want.len)     diff = {diff, " token_length"};
		if (got.last !== want.last)   diff = {diff, " last"};
		if (diff != "")
			report({"descriptor #", $sformatf("%0d", checked), " differs in", diff}, got, want);
	endfunction

	function int pending();
		return pending_tokens.size();
	endfunction
endclass

module tb_irc_line_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_BYTES  = 1024;
	localparam int MAX_PARAMS    = 16;
	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 12;
	// Idle time after the drain, with margin over a full line's table walk.
	localparam int SETTLE_CYCLES = 2 * (2 * (MAX_PARAMS + 2) + 1);
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_CYCLES  = 2_000_000;
	localparam int RANDOM_BYTES  = 360;
	localparam int RANDOM_DESCS  = 60;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

	logic clk;
	logic arst_n;

	irclt_byte_if line_bytes();
	irclt_tok_if  tokens();

	irc_line_tokenizer #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.MAX_PARAMS  (MAX_PARAMS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_bytes(line_bytes),
		.tokens    (tokens)
	);

	token_scoreboard #(BUFFER_BYTES, MAX_PARAMS) sb;

	logic [7:0] msg_q[$];   // line being assembled, newline excluded
	int         burst_left;
	int         bytes_sent;
	bit         hold_req;   // asks the receiver for its long hold-off

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("ERROR: run did not finish in time, %0d descriptors outstanding", sb.pending());
		$display("irc_line_tokenizer: mismatch");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Byte request driver. The sender runs in bursts; before each burst it
	// may drop valid for a random gap. Within a burst valid stays high and
	// only the payload moves, so valid never sees two NBAs in one step.
	// Acceptance is judged on the pre-edge values of valid and ready.
	// ---------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				line_bytes.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		line_bytes.valid     <= 1'b1;
		line_bytes.data_byte <= b;
		@(posedge clk);
		while (!line_bytes.ready)
			@(posedge clk);
		sb.take_byte(b);
		burst_left--;
		bytes_sent++;
	endtask

	// Append text to the assembled line, send it with its newline, clear it.
	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_q.push_back(s[i]);
		foreach (msg_q[i])
			send_byte(msg_q[i]);
		send_byte(CH_LF);
		msg_q.delete();
	endtask

	// Token byte: anything printable-or-high that is not a separator.
	function automatic logic [7:0] word_char();
		logic [7:0] c;
		do c = 8'($urandom_range(33, 255)); while (c == CH_COLON);
		return c;
	endfunction

	function automatic void add_word(int n);
		repeat (n) msg_q.push_back(word_char());
	endfunction

	function automatic void add_spaces(int n);
		repeat (n) msg_q.push_back(CH_SPACE);
	endfunction

	// ---------------------------------------------------------------------
	// Descriptor receiver: ready follows segments of random length, each in
	// one of three modes (always open, coin flip, high a third of the time). On
	// request it holds ready low for a long stretch so the block backs up
	// and stalls its byte input.
	// ---------------------------------------------------------------------
	initial begin
		rx_mode_e mode;
		int       seg_len;
		int       tick;
		tick = 0;
		tokens.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				tokens.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode    = rx_mode_e'($urandom_range(0, 2));
			seg_len = $urandom_range(10, 60);
			repeat (seg_len) begin
				case (mode)
					RX_OPEN:   tokens.ready <= 1'b1;
					RX_RANDOM: tokens.ready <= 1'($urandom_range(0, 1));
					default:   tokens.ready <= (tick % 3 == 0);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	// Descriptor monitor: every accepted descriptor goes to the scoreboard.
	always @(posedge clk) begin
		token_desc_t got;
		if (arst_n && tokens.valid && tokens.ready) begin
			got.kind  = kind_t'(tokens.kind);
			got.idx   = tokens.param_index;
			got.start = tokens.token_start;
			got.len   = tokens.token_length;
			got.last  = tokens.last;
			sb.check_descriptor(got);
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus: reset, directed lines, then random lines, then drain.
	// ---------------------------------------------------------------------
	initial begin
		int         rand_start;
		int         desc_start;
		int         nparams;
		logic [7:0] c;
		sb         = new();
		burst_left = 0;
		bytes_sent = 0;
		hold_req   = 1'b0;
		arst_n               <= 1'b0;
		line_bytes.valid     <= 1'b0;
		line_bytes.data_byte <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full message: prefix, command, a middle, trailing, CRs stripped.
		send_line(":nick!u@h PRIVMSG #chan :hello world\015\015");
		// Empty, blank and prefix-only lines carry no command.
		send_line("");
		send_line("   ");
		send_line(":server.only");
		// Empty prefix, then leading spaces, wide gaps and an empty trailing.
		send_line(": PING");
		send_line("   NICK  a   b  :");
		// Command of CRs only, then a middle of CRs only.
		send_line("\015\015");
		send_line("JOIN \015\015");
		// CR inside a middle stays, the trailing CR is clipped.
		send_line("CMD a\015b\015");
		// Zero byte ends the content; the rest is stored but not parsed.
		msg_q.push_back("A");
		msg_q.push_back("B");
		msg_q.push_back(CH_NUL);
		send_line(" x :y");
		msg_q.push_back(CH_NUL);
		send_line("CMD");
		// High bytes in the command, DEL in the parameter.
		msg_q.push_back(8'hFF);
		msg_q.push_back(8'h80);
		msg_q.push_back(CH_SPACE);
		msg_q.push_back(8'h7F);
		send_line("x");
		// Twenty middles and a trailing: only sixteen make it out, the trailing too is cut.
		msg_q.push_back(CH_COLON);
		msg_q.push_back("p");
		send_line(" CMD 1 2 3 4 5 6 7 8 9 10 11 12 13 14 15 16 17 18 19 20 :t");
		// 1023 bytes, the most that is kept: trailing at the top offset.
		msg_q.push_back("C");
		add_spaces(1020);
		send_line(":z");
		// 1023 bytes of command: longest token.
		msg_q.push_back("X");
		add_word(1022);
		send_line("");
		// One byte more than fits: dropped line, then a normal one.
		add_word(BUFFER_BYTES);
		send_line("");
		send_line("QUIT");

		// Random part opens with the receiver's long hold-off.
		hold_req   = 1'b1;
		rand_start = bytes_sent;
		desc_start = sb.predicted;
		while (bytes_sent - rand_start < RANDOM_BYTES || sb.predicted - desc_start < RANDOM_DESCS) begin
			if ($urandom_range(0, 99) < 82) begin
				// well-formed message with random content
				if ($urandom_range(0, 4) == 0)
					add_spaces($urandom_range(1, 3));
				if ($urandom_range(0, 2) == 0) begin
					msg_q.push_back(CH_COLON);
					add_word($urandom_range(0, 8));
					add_spaces($urandom_range(1, 2));
				end
				add_word($urandom_range(1, 6));
				nparams = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) :
					$urandom_range(0, 4);
				repeat (nparams) begin
					add_spaces($urandom_range(1, 3));
					add_word($urandom_range(1, 5));
				end
				if ($urandom_range(0, 2) == 0) begin
					add_spaces(1);
					msg_q.push_back(CH_COLON);
					repeat ($urandom_range(0, 10))
						msg_q.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : word_char());
				end
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 2)) msg_q.push_back(CH_CR);
				if ($urandom_range(0, 19) == 0)
					msg_q.insert($urandom_range(0, msg_q.size()), CH_NUL);
			end else begin
				// noise: any bytes but the newline
				repeat ($urandom_range(0, 12)) begin
					do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
					msg_q.push_back(c);
				end
			end
			send_line("");
		end
		line_bytes.valid <= 1'b0;

		// Drain, then let the block sit idle to catch stray descriptors.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d bytes in %0d lines (random part %0d bytes), incl. overlong and commandless lines",
			bytes_sent, sb.lines, bytes_sent - rand_start);
		$display("Checked %0d descriptors, %0d of them status items; %0d failures",
			sb.checked, sb.status_items, sb.failures);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("irc_line_tokenizer: match");
		else
			$display("irc_line_tokenizer: mismatch");
		$finish;
	end

endmodule
